/* hdl/nmeachk_pkg.sv */
`timescale 1ns / 1ps

package nmeachk_pkg;

	localparam int DEF_MAX_FIELDS       = 32;
	localparam int DEF_MAX_SENTENCE_LEN = 82;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	localparam logic [2:0] KIND_IGNORED    = 3'd0;
	localparam logic [2:0] KIND_FIELD_CHAR = 3'd1;
	localparam logic [2:0] KIND_FIELD_END  = 3'd2;
	localparam logic [2:0] KIND_SENT_END   = 3'd3;
	localparam logic [2:0] KIND_SENT_START = 3'd4;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BODY = 2'd1,
		PH_HEX1 = 2'd2,
		PH_HEX2 = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		HEX_VALID = 2'd0,
		HEX_LOWER = 2'd1,
		HEX_BAD   = 2'd2
	} hex_class_t;

	typedef struct packed {
		logic [2:0]  byte_kind;
		logic [4:0]  field_index;
		logic [7:0]  data_byte;
		logic [15:0] field_value;
		logic        checksum_ok;
		logic        sentence_error;
	} result_t;

endpackage

/* hdl/nmea_sentence_checker_tokenizer.sv */
`timescale 1ns / 1ps

// NMEA 0183 sentence checker and tokenizer.
// Input channel: one received character per request (rx_byte, in_valid/in_ready).
// Output channel: one result per input character (byte_kind, field_index,
// data_byte, field_value, checksum_ok, sentence_error, out_valid/out_ready).
// byte_kind: ignored, field char, field end (field_value holds the saturated
// decimal value of the field's leading digits), sentence end (checksum_ok and
// sentence_error valid), sentence start on '$'.
// Output: each result is registered in out_q, or in skid_q while the receiver stalls.
// Throughput: one character per cycle while in_ready is high; the per-byte parser
// state update is combinational logic ahead of the result register.
// Stall: a result register plus one skid entry; while the receiver stalls a
// second request is still taken, then in_ready drops until the skid drains.
// Reset: arst_n clears parser state (idle, waiting for '$') and empties both result
// entries. Any '$' restarts a sentence; the previous one gets no end result.
module nmea_sentence_checker_tokenizer #(
	parameter int MAX_FIELDS       = nmeachk_pkg::DEF_MAX_FIELDS,
	parameter int MAX_SENTENCE_LEN = nmeachk_pkg::DEF_MAX_SENTENCE_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  byte_kind,
	output logic [4:0]  field_index,
	output logic [7:0]  data_byte,
	output logic [15:0] field_value,
	output logic        checksum_ok,
	output logic        sentence_error
);
	import nmeachk_pkg::*;

	localparam int FieldTop = (MAX_FIELDS - 1 < 31) ? MAX_FIELDS - 1 : 31;

	logic    accept;
	result_t res_new;
	result_t out_q;
	result_t skid_q;
	logic    out_v_q;
	logic    skid_v_q;

	assign in_ready = !skid_v_q;
	assign accept   = in_valid && in_ready;

	nmeachk_parse #(
		.MAX_FIELDS       (MAX_FIELDS),
		.MAX_SENTENCE_LEN (MAX_SENTENCE_LEN)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.res     (res_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q) out_q <= skid_q;
			else if (accept) out_q <= res_new;
		end else if (accept) begin
			skid_q <= res_new;
		end
	end

	assign out_valid      = out_v_q;
	assign byte_kind      = out_q.byte_kind;
	assign field_index    = out_q.field_index;
	assign data_byte      = out_q.data_byte;
	assign field_value    = out_q.field_value;
	assign checksum_ok    = out_q.checksum_ok;
	assign sentence_error = out_q.sentence_error;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with empty output register");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !out_v_q |=> out_v_q)
		else $error("accepted request produced no result");

	a_ok_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && checksum_ok |-> byte_kind == KIND_SENT_END && !sentence_error)
		else $error("checksum_ok outside a clean sentence end");

	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> field_index <= 5'(FieldTop))
		else $error("field index beyond limit");

	a_value_at_field_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && byte_kind != KIND_FIELD_END |-> field_value == 16'd0)
		else $error("field value outside field end");
`endif

endmodule

/* hdl/nmeachk_parse.sv */
`timescale 1ns / 1ps

module nmeachk_parse #(
	parameter int MAX_FIELDS       = nmeachk_pkg::DEF_MAX_FIELDS,
	parameter int MAX_SENTENCE_LEN = nmeachk_pkg::DEF_MAX_SENTENCE_LEN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	output nmeachk_pkg::result_t res
);
	import nmeachk_pkg::*;

	localparam int FieldTop = (MAX_FIELDS - 1 < 31) ? MAX_FIELDS - 1 : 31;

	phase_t      phase_q, phase_d;
	logic [7:0]  xor_q, xor_d;
	logic [4:0]  field_q, field_d;
	logic [15:0] acc_q, acc_d;
	logic        stopped_q, stopped_d;
	logic [3:0]  hexhi_q, hexhi_d;
	logic [6:0]  bcnt_q, bcnt_d;
	logic        err_q, err_d;

	logic        is_digit;
	logic [3:0]  digit;
	logic [19:0] acc_mul;
	hex_class_t  hcls;
	logic [3:0]  hnib;
	logic        overlong;
	logic        match;

	always_comb begin
		hcls = HEX_BAD;
		hnib = 4'd0;
		if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
			hcls = HEX_VALID;
			hnib = rx_byte[3:0];
		end else if (rx_byte >= 8'h41 && rx_byte <= 8'h46) begin
			hcls = HEX_VALID;
			hnib = rx_byte[3:0] + 4'd9;
		end else if (rx_byte >= 8'h61 && rx_byte <= 8'h66) begin
			hcls = HEX_LOWER;
		end
	end

	assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
	assign digit    = rx_byte[3:0];
	assign acc_mul  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {16'd0, digit};
	assign overlong = bcnt_q >= 7'(MAX_SENTENCE_LEN);
	assign match    = (hcls == HEX_VALID) && ({hexhi_q, hnib} == xor_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (rx_byte == CH_DOLLAR) begin
			phase_d = PH_BODY;
		end else begin
			unique case (phase_q)
				PH_IDLE: phase_d = PH_IDLE;
				PH_BODY: if (rx_byte == CH_STAR) phase_d = PH_HEX1;
				PH_HEX1: phase_d = PH_HEX2;
				PH_HEX2: phase_d = PH_IDLE;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// datapath and result
	always_comb begin
		xor_d     = xor_q;
		field_d   = field_q;
		acc_d     = acc_q;
		stopped_d = stopped_q;
		hexhi_d   = hexhi_q;
		bcnt_d    = bcnt_q;
		err_d     = err_q;

		res                = '0;
		res.data_byte      = rx_byte;
		res.field_index    = field_q;
		res.byte_kind      = KIND_IGNORED;

		if (rx_byte == CH_DOLLAR) begin
			xor_d           = '0;
			field_d         = '0;
			acc_d           = '0;
			stopped_d       = 1'b0;
			hexhi_d         = '0;
			bcnt_d          = 7'd1;
			err_d           = 1'b0;
			res.byte_kind   = KIND_SENT_START;
			res.field_index = '0;
		end else begin
			if (phase_q != PH_IDLE) begin
				if (overlong) err_d = 1'b1;
				else bcnt_d = bcnt_q + 7'd1;
			end
			unique case (phase_q)
				PH_IDLE: ;
				PH_BODY: begin
					if (rx_byte == CH_COMMA || rx_byte == CH_STAR) begin
						res.byte_kind   = KIND_FIELD_END;
						res.field_value = acc_q;
						if (rx_byte == CH_COMMA) begin
							xor_d = xor_q ^ rx_byte;
							if (field_q < 5'(FieldTop)) field_d = field_q + 5'd1;
						end
						acc_d     = '0;
						stopped_d = 1'b0;
					end else begin
						xor_d         = xor_q ^ rx_byte;
						res.byte_kind = KIND_FIELD_CHAR;
						if (!stopped_q && is_digit) begin
							acc_d = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
						end else begin
							stopped_d = 1'b1;
						end
					end
				end
				PH_HEX1: begin
					if (hcls == HEX_BAD) err_d = 1'b1;
					hexhi_d = (hcls == HEX_VALID) ? hnib : ~xor_q[7:4];
				end
				PH_HEX2: begin
					if (hcls == HEX_BAD) err_d = 1'b1;
					res.byte_kind      = KIND_SENT_END;
					res.sentence_error = err_d;
					res.checksum_ok    = match && !err_d;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			xor_q     <= '0;
			field_q   <= '0;
			acc_q     <= '0;
			stopped_q <= 1'b0;
			hexhi_q   <= '0;
			bcnt_q    <= '0;
			err_q     <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			xor_q     <= xor_d;
			field_q   <= field_d;
			acc_q     <= acc_d;
			stopped_q <= stopped_d;
			hexhi_q   <= hexhi_d;
			bcnt_q    <= bcnt_d;
			err_q     <= err_d;
		end
	end

endmodule
